>>> src/ppp_pkg.sv
// Shared widths, selector codes and control bundles for the polyline point projection.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ppp_pkg;

   localparam int XW    = 32;        // coordinate width
   localparam int DW    = XW + 1;    // coordinate difference width
   localparam int OPW   = 36;        // multiplier operand width (signed)
   localparam int PW    = 2 * OPW;   // product / accumulator width
   localparam int RW    = 34;        // segment length width
   localparam int QW    = OPW;       // kept quotient width
   localparam int AW    = 40;        // arc length width
   localparam int DISTW = 64;        // squared distance width
   localparam int CFGW  = 16;        // min_segment_length width

   typedef enum logic [2:0] {
      MS_DXDX,
      MS_DYDY,
      MS_UXDX,
      MS_UYDY,
      MS_DXUY,
      MS_DYUX,
      MS_OFF,
      MS_ERR
   } mul_sel_type;

   typedef enum logic [1:0] {
      AM_LOAD,
      AM_ADD,
      AM_SUB
   } acc_mode_type;

   typedef struct packed {
      logic         accept;
      logic         mul_start;
      mul_sel_type  mul_sel;
      acc_mode_type acc_mode;
      logic         sqrt_start;
      logic         abs_load;
      logic         div_start;
      logic         div_to_off;
      logic         clamp;
      logic         update;
      logic         finish;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic sqrt_done;
      logic div_done;
      logic seg;
      logic degen;
      logic last;
      logic rsp_free;
   } status_type;

endpackage

>>> src/ppp_mul.sv
// Iterative signed multiplier: four 18x18 partial products, then sign fix.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [ppp_pkg::OPW-1:0] a,
   input  logic signed [ppp_pkg::OPW-1:0] b,
   output logic                         done,
   output logic signed [ppp_pkg::PW-1:0]  prod
);
   import ppp_pkg::*;

   localparam int HW = OPW / 2;

   logic [OPW-1:0]    ma_ff, ma_in, mb_ff, mb_in;
   logic              neg_ff, neg_in;
   logic [PW-1:0]     acc_ff, acc_in;
   logic [2:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [HW-1:0]     a_half, b_half;
   logic [2*HW-1:0]   pp;
   logic [PW-1:0]     pp_sh;

   assign a_half = step_ff[1] ? ma_ff[OPW-1:HW] : ma_ff[HW-1:0];
   assign b_half = step_ff[0] ? mb_ff[OPW-1:HW] : mb_ff[HW-1:0];
   assign pp     = a_half * b_half;

   always_comb begin
      case (step_ff)
         3'd0:    pp_sh = PW'(pp);
         3'd1,
         3'd2:    pp_sh = PW'(pp) << HW;
         3'd3:    pp_sh = PW'(pp) << (2 * HW);
         default: pp_sh = '0;
      endcase
   end

   always_comb begin
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      if (start) begin
         ma_in   = a[OPW-1] ? OPW'(-a) : OPW'(a);
         mb_in   = b[OPW-1] ? OPW'(-b) : OPW'(b);
         neg_in  = a[OPW-1] ^ b[OPW-1];
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 3'd4) begin
            prod_in = neg_ff ? -signed'(acc_ff) : signed'(acc_ff);
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            acc_in  = acc_ff + pp_sh;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

>>> src/ppp_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ppp_pkg::PW-1:0]  rad,
   output logic                    done,
   output logic [ppp_pkg::RW-1:0]  root
);
   import ppp_pkg::*;

   localparam int NI   = PW / 2;
   localparam int REMW = NI + 3;
   localparam int CW   = $clog2(NI + 1);

   logic [PW-1:0]   rad_ff, rad_in;
   logic [NI-1:0]   root_ff, root_in;
   logic [REMW-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   assign rem_sh = {rem_ff[REMW-3:0], rad_ff[PW-1:PW-2]};
   assign trial  = REMW'({root_ff, 2'b01});

   always_comb begin
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[NI-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[NI-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NI - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff[RW-1:0];

endmodule

>>> src/ppp_div.sv
// Restoring divider, one quotient bit per cycle; adds half the divisor for rounding.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [ppp_pkg::PW-1:0]  mag,
   input  logic [ppp_pkg::RW-1:0]  den,
   output logic                    done,
   output logic [ppp_pkg::QW-1:0]  quo
);
   import ppp_pkg::*;

   localparam int CW = $clog2(PW + 1);

   logic [PW-1:0] num_ff, num_in;
   logic [RW-1:0] den_ff, den_in;
   logic [RW:0]   rem_ff, rem_in, rem_sh;
   logic [QW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   assign rem_sh = {rem_ff[RW-1:0], num_ff[PW-1]};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = mag + PW'(den >> 1);
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(PW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

>>> src/ppp_datapath.sv
// Datapath: running polyline state, segment arithmetic and result word register.
// Depends on ppp_pkg, ppp_mul, ppp_sqrt and ppp_div.
`timescale 1ns / 1ps
module ppp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ppp_pkg::cmd_type        cmd,
   output ppp_pkg::status_type     status,
   input  logic [4*ppp_pkg::XW-1:0] req_data,
   input  logic                    req_first,
   input  logic                    req_last,
   input  logic                    csr_write,
   input  logic [ppp_pkg::CFGW-1:0] csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [ppp_pkg::AW-1:0]  rsp_along,
   output logic [ppp_pkg::XW-1:0]  rsp_offset
);
   import ppp_pkg::*;

   logic [CFGW-1:0]         msl_ff;
   logic [XW-1:0]           prev_x_ff, prev_y_ff, vx_ff, vy_ff;
   logic                    have_prev_ff, has_proj_ff, last_ff;
   logic [AW-1:0]           accum_ff, best_along_ff;
   logic [DISTW-1:0]        best_dist_ff;
   logic [XW-1:0]           best_off_ff;
   logic signed [DW-1:0]    dx_ff, dy_ff, ux_ff, uy_ff;
   logic signed [PW-1:0]    acc_ff;
   logic [RW-1:0]           len_ff;
   logic [PW-1:0]           mag_ff;
   logic                    sign_ff;
   logic signed [OPW-1:0]   t_ff, off_ff, e_ff;
   logic [RW-1:0]           s_ff;
   logic                    rsp_valid_ff, rsp_found_ff;
   logic [AW-1:0]           rsp_along_ff;
   logic [XW-1:0]           rsp_off_ff;

   logic signed [XW-1:0]    in_vx, in_vy, in_qx, in_qy;
   logic signed [OPW-1:0]   op_a, op_b, div_val, len_s;
   logic                    mul_done, sqrt_done, div_done;
   logic signed [PW-1:0]    prod;
   logic [RW-1:0]           root;
   logic [QW-1:0]           quo;
   logic [DISTW-1:0]        dist_sq;
   logic                    take;
   logic [AW:0]             along_sum, accum_sum;
   logic [XW-1:0]           off_sat;

   assign in_vx = req_data[XW-1:0];
   assign in_vy = req_data[2*XW-1:XW];
   assign in_qx = req_data[3*XW-1:2*XW];
   assign in_qy = req_data[4*XW-1:3*XW];

   always_comb begin
      case (cmd.mul_sel)
         MS_DXDX: begin op_a = OPW'(dx_ff); op_b = OPW'(dx_ff); end
         MS_DYDY: begin op_a = OPW'(dy_ff); op_b = OPW'(dy_ff); end
         MS_UXDX: begin op_a = OPW'(ux_ff); op_b = OPW'(dx_ff); end
         MS_UYDY: begin op_a = OPW'(uy_ff); op_b = OPW'(dy_ff); end
         MS_DXUY: begin op_a = OPW'(dx_ff); op_b = OPW'(uy_ff); end
         MS_DYUX: begin op_a = OPW'(dy_ff); op_b = OPW'(ux_ff); end
         MS_OFF:  begin op_a = off_ff;      op_b = off_ff;      end
         MS_ERR:  begin op_a = e_ff;        op_b = e_ff;        end
         default: begin op_a = '0;          op_b = '0;          end
      endcase
   end

   ppp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (op_a),
      .b     (op_b),
      .done  (mul_done),
      .prod  (prod)
   );

   ppp_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .rad   (PW'(acc_ff)),
      .done  (sqrt_done),
      .root  (root)
   );

   ppp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .mag   (mag_ff),
      .den   (len_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign div_val   = sign_ff ? -signed'(quo) : signed'(quo);
   assign len_s     = signed'(OPW'(len_ff));
   assign dist_sq   = (acc_ff[PW-1:DISTW] != '0) ? '1 : acc_ff[DISTW-1:0];
   assign take      = !has_proj_ff || (dist_sq < best_dist_ff);
   assign along_sum = {1'b0, accum_ff} + (AW + 1)'(s_ff);
   assign accum_sum = {1'b0, accum_ff} + (AW + 1)'(len_ff);

   always_comb begin
      if (off_ff > signed'(OPW'({1'b0, {(XW - 1){1'b1}}})))
         off_sat = {1'b0, {(XW - 1){1'b1}}};
      else if (off_ff < -signed'(OPW'({1'b1, {(XW - 1){1'b0}}})))
         off_sat = {1'b1, {(XW - 1){1'b0}}};
      else
         off_sat = off_ff[XW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msl_ff        <= CFGW'(7);
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_prev_ff  <= 1'b0;
         accum_ff      <= '0;
         best_dist_ff  <= '1;
         best_along_ff <= '0;
         best_off_ff   <= '0;
         has_proj_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write)
            msl_ff <= csr_data;
         if ((cmd.accept && req_first) || cmd.emit) begin
            prev_x_ff     <= '0;
            prev_y_ff     <= '0;
            have_prev_ff  <= 1'b0;
            accum_ff      <= '0;
            best_dist_ff  <= '1;
            best_along_ff <= '0;
            best_off_ff   <= '0;
            has_proj_ff   <= 1'b0;
         end
         if (cmd.update) begin
            if (take) begin
               best_dist_ff  <= dist_sq;
               best_along_ff <= along_sum[AW] ? '1 : along_sum[AW-1:0];
               best_off_ff   <= off_sat;
               has_proj_ff   <= 1'b1;
            end
            accum_ff <= accum_sum[AW] ? '1 : accum_sum[AW-1:0];
         end
         if (cmd.finish) begin
            prev_x_ff    <= vx_ff;
            prev_y_ff    <= vy_ff;
            have_prev_ff <= 1'b1;
         end
         if (cmd.emit)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         vx_ff   <= in_vx;
         vy_ff   <= in_vy;
         last_ff <= req_last;
         dx_ff   <= DW'(in_vx) - DW'(signed'(prev_x_ff));
         dy_ff   <= DW'(in_vy) - DW'(signed'(prev_y_ff));
         ux_ff   <= DW'(in_qx) - DW'(signed'(prev_x_ff));
         uy_ff   <= DW'(in_qy) - DW'(signed'(prev_y_ff));
      end
      if (mul_done) begin
         case (cmd.acc_mode)
            AM_LOAD: acc_ff <= prod;
            AM_ADD:  acc_ff <= acc_ff + prod;
            AM_SUB:  acc_ff <= acc_ff - prod;
            default: acc_ff <= acc_ff;
         endcase
      end
      if (sqrt_done)
         len_ff <= root;
      if (cmd.abs_load) begin
         sign_ff <= acc_ff[PW-1];
         mag_ff  <= acc_ff[PW-1] ? PW'(-acc_ff) : PW'(acc_ff);
      end
      if (div_done) begin
         if (cmd.div_to_off)
            off_ff <= div_val;
         else
            t_ff <= div_val;
      end
      if (cmd.clamp) begin
         if (t_ff < 0) begin
            s_ff <= '0;
            e_ff <= t_ff;
         end else if (t_ff > len_s) begin
            s_ff <= len_ff;
            e_ff <= t_ff - len_s;
         end else begin
            s_ff <= t_ff[RW-1:0];
            e_ff <= '0;
         end
      end
      if (cmd.emit) begin
         rsp_found_ff <= has_proj_ff;
         rsp_along_ff <= has_proj_ff ? best_along_ff : '0;
         rsp_off_ff   <= has_proj_ff ? best_off_ff : '0;
      end
   end

   assign status.mul_done  = mul_done;
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;
   assign status.seg       = have_prev_ff && !req_first;
   assign status.degen     = len_ff <= RW'(msl_ff);
   assign status.last      = last_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_along  = rsp_along_ff;
   assign rsp_offset = rsp_off_ff;

endmodule

>>> src/ppp_ctrl.sv
// Controller: sequences one vertex through multiply, root, divide and update steps.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output ppp_pkg::cmd_type    cmd,
   input  ppp_pkg::status_type status
);
   import ppp_pkg::*;

   typedef enum logic [18:0] {
      ST_IDLE    = 19'h00001,
      ST_SQ_DX   = 19'h00002,
      ST_SQ_DY   = 19'h00004,
      ST_ROOT    = 19'h00008,
      ST_CHECK   = 19'h00010,
      ST_DOT_X   = 19'h00020,
      ST_DOT_Y   = 19'h00040,
      ST_DOT_ABS = 19'h00080,
      ST_DOT_DIV = 19'h00100,
      ST_CR_A    = 19'h00200,
      ST_CR_B    = 19'h00400,
      ST_CR_ABS  = 19'h00800,
      ST_CR_DIV  = 19'h01000,
      ST_CLAMP   = 19'h02000,
      ST_OFF_SQ  = 19'h04000,
      ST_ERR_SQ  = 19'h08000,
      ST_UPDATE  = 19'h10000,
      ST_FINISH  = 19'h20000,
      ST_EMIT    = 19'h40000
   } state_type;

   state_type state_ff, state_in;
   logic      issued_ff, issued_in;

   always_comb begin
      state_in  = state_ff;
      issued_in = 1'b0;
      cmd       = '0;
      cmd.mul_sel  = MS_DXDX;
      cmd.acc_mode = AM_LOAD;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid)
               state_in = status.seg ? ST_SQ_DX : ST_FINISH;
         end
         ST_SQ_DX, ST_SQ_DY, ST_DOT_X, ST_DOT_Y, ST_CR_A, ST_CR_B,
         ST_OFF_SQ, ST_ERR_SQ: begin
            cmd.mul_start = !issued_ff;
            issued_in     = !status.mul_done;
            case (state_ff)
               ST_SQ_DX:  begin cmd.mul_sel = MS_DXDX; cmd.acc_mode = AM_LOAD; end
               ST_SQ_DY:  begin cmd.mul_sel = MS_DYDY; cmd.acc_mode = AM_ADD;  end
               ST_DOT_X:  begin cmd.mul_sel = MS_UXDX; cmd.acc_mode = AM_LOAD; end
               ST_DOT_Y:  begin cmd.mul_sel = MS_UYDY; cmd.acc_mode = AM_ADD;  end
               ST_CR_A:   begin cmd.mul_sel = MS_DXUY; cmd.acc_mode = AM_LOAD; end
               ST_CR_B:   begin cmd.mul_sel = MS_DYUX; cmd.acc_mode = AM_SUB;  end
               ST_OFF_SQ: begin cmd.mul_sel = MS_OFF;  cmd.acc_mode = AM_LOAD; end
               default:   begin cmd.mul_sel = MS_ERR;  cmd.acc_mode = AM_ADD;  end
            endcase
            if (status.mul_done) begin
               case (state_ff)
                  ST_SQ_DX:  state_in = ST_SQ_DY;
                  ST_SQ_DY:  state_in = ST_ROOT;
                  ST_DOT_X:  state_in = ST_DOT_Y;
                  ST_DOT_Y:  state_in = ST_DOT_ABS;
                  ST_CR_A:   state_in = ST_CR_B;
                  ST_CR_B:   state_in = ST_CR_ABS;
                  ST_OFF_SQ: state_in = ST_ERR_SQ;
                  default:   state_in = ST_UPDATE;
               endcase
            end
         end
         ST_ROOT: begin
            cmd.sqrt_start = !issued_ff;
            issued_in      = !status.sqrt_done;
            if (status.sqrt_done)
               state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.degen ? ST_FINISH : ST_DOT_X;
         end
         ST_DOT_ABS: begin
            cmd.abs_load = 1'b1;
            state_in     = ST_DOT_DIV;
         end
         ST_CR_ABS: begin
            cmd.abs_load = 1'b1;
            state_in     = ST_CR_DIV;
         end
         ST_DOT_DIV, ST_CR_DIV: begin
            cmd.div_start  = !issued_ff;
            cmd.div_to_off = (state_ff == ST_CR_DIV);
            issued_in      = !status.div_done;
            if (status.div_done)
               state_in = (state_ff == ST_CR_DIV) ? ST_CLAMP : ST_CR_A;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_OFF_SQ;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = status.last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

endmodule

>>> src/polyline_point_projection.sv
// One vertex at a time: the next vertex word is taken only once the current vertex is done,
// and after a last vertex once the result word has been issued, which result stalls can delay.
// Two divides, a root and eight multiplies on the shared multiplier set the per-vertex time
// of a full segment; a degenerate segment stops after the root, and no segment skips them all.
// Reset (synchronous) clears the running polyline state and sets min_segment_length to 7.
`timescale 1ns / 1ps
module polyline_point_projection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [4*ppp_pkg::XW-1:0]      req_tdata,  // vertex_x, vertex_y, query_x, query_y
   input  logic                          req_tuser,  // first_vertex
   input  logic                          req_tlast,  // last_vertex
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ppp_pkg::AW+ppp_pkg::XW-1:0] rsp_tdata,  // along, offset
   output logic                          rsp_tuser,  // found
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ppp_pkg::CFGW-1:0]      csr_wdata   // min_segment_length
);
   import ppp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [AW-1:0] along;
   logic [XW-1:0] offset;

   assign csr_ready = 1'b1;

   ppp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   ppp_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_tdata),
      .req_first  (req_tuser),
      .req_last   (req_tlast),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_found  (rsp_tuser),
      .rsp_along  (along),
      .rsp_offset (offset)
   );

   assign rsp_tdata = {offset, along};

endmodule

>>> src/ppp_checker.sv
// Port-level checks for polyline_point_projection, attached by bind.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
module ppp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [ppp_pkg::AW+ppp_pkg::XW-1:0] rsp_tdata,
   input logic                          rsp_tuser
);
   import ppp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("nonzero fields without a projection");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while busy");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after a non-final vertex");

endmodule

bind polyline_point_projection ppp_checker u_ppp_checker (.*);
